>>> hw/rtl/sorted_list_engine_assert.svh
// assertion macros for the sorted list engine checker
`ifndef SORTED_LIST_ENGINE_ASSERT_SVH
`define SORTED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication
`define SLE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted list engine: same-cycle check failed");

// next-cycle implication
`define SLE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted list engine: next-cycle check failed");

`endif

>>> hw/rtl/sle_pkg.sv
`default_nettype none
package sle_pkg;

   localparam int LIST_CAPACITY = 16;
   localparam int IDX_W = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
   localparam int CNT_W = $clog2(LIST_CAPACITY + 1);
   localparam int VAL_W = 32;
   localparam int OP_W  = 3;
   localparam int ST_W  = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT    = 3'd0,
      OP_REMOVE    = 3'd1,
      OP_LIST_ASC  = 3'd2,
      OP_LIST_DESC = 3'd3,
      OP_CLEAR     = 3'd4
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS,
      S_INS_HEAD,
      S_REM_SCAN,
      S_REM_SHIFT,
      S_WALK,
      S_EMIT
   } state_type;

   // compare unit outputs
   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_type;

   // one result from the sequencer to the output register
   typedef struct packed {
      logic              valid;
      status_type        status;
      logic [VAL_W-1:0]  value;
      logic              last;
   } result_type;

endpackage
`default_nettype wire

>>> hw/rtl/sle_cmp.sv
`default_nettype none
module sle_cmp (
   input  wire logic signed [sle_pkg::VAL_W-1:0] a,
   input  wire logic signed [sle_pkg::VAL_W-1:0] b,
   output sle_pkg::cmp_type                      res
);

   // shared signed compare, one use per cycle
   always_comb begin
      res.lt = (a < b);
      res.eq = (a == b);
   end

endmodule
`default_nettype wire

>>> hw/rtl/sle_core.sv
`default_nettype none
module sle_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [sle_pkg::OP_W-1:0]      req_op,
   input  wire logic [sle_pkg::VAL_W-1:0]     req_value,
   input  wire logic                          space,
   output sle_pkg::result_type                res
);

   sle_pkg::state_type                 state_ff, state_in;
   sle_pkg::op_type                    op_ff, op_in;
   logic [sle_pkg::VAL_W-1:0]          val_ff, val_in;
   logic [sle_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic [sle_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   sle_pkg::status_type                status_ff, status_in;

   logic [sle_pkg::VAL_W-1:0]          mem_ff [sle_pkg::LIST_CAPACITY];
   logic [sle_pkg::VAL_W-1:0]          rdata_ff;
   logic                               rd_en;
   logic [sle_pkg::IDX_W-1:0]          rd_addr;
   logic                               wr_en;
   logic [sle_pkg::IDX_W-1:0]          wr_addr;
   logic [sle_pkg::VAL_W-1:0]          wr_data;

   sle_pkg::cmp_type                   cmp;
   logic [sle_pkg::IDX_W-1:0]          last_idx;
   logic                               is_full;
   logic                               is_empty;
   logic                               walk_end;

   sle_cmp u_cmp (
      .a   (rdata_ff),
      .b   (val_ff),
      .res (cmp)
   );

   assign last_idx = sle_pkg::IDX_W'(cnt_ff - sle_pkg::CNT_W'(1));
   assign is_full  = (cnt_ff == sle_pkg::CNT_W'(sle_pkg::LIST_CAPACITY));
   assign is_empty = (cnt_ff == '0);
   assign walk_end = (op_ff == sle_pkg::OP_LIST_DESC) ? (idx_ff == '0) : (idx_ff == last_idx);

   // value store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sle_pkg::S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      op_ff     <= op_in;
      val_ff    <= val_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      val_in     = val_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      status_in  = status_ff;
      rd_en      = 1'b0;
      rd_addr    = idx_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = val_ff;
      req_ready  = (state_ff == sle_pkg::S_IDLE);
      res.valid  = 1'b0;
      res.status = sle_pkg::ST_OK;
      res.value  = '0;
      res.last   = 1'b0;

      case (state_ff)
         sle_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in  = sle_pkg::op_type'(req_op);
               val_in = req_value;
               case (sle_pkg::op_type'(req_op))
                  sle_pkg::OP_INSERT: begin
                     if (is_full) begin
                        status_in = sle_pkg::ST_FULL;
                        state_in  = sle_pkg::S_EMIT;
                     end else if (is_empty) begin
                        wr_en     = 1'b1;
                        wr_addr   = '0;
                        wr_data   = req_value;
                        cnt_in    = sle_pkg::CNT_W'(1);
                        status_in = sle_pkg::ST_OK;
                        state_in  = sle_pkg::S_EMIT;
                     end else begin
                        // walk down from the tail, shifting up as we go
                        rd_en    = 1'b1;
                        rd_addr  = last_idx;
                        idx_in   = last_idx;
                        state_in = sle_pkg::S_INS;
                     end
                  end
                  sle_pkg::OP_REMOVE: begin
                     if (is_empty) begin
                        status_in = sle_pkg::ST_EMPTY;
                        state_in  = sle_pkg::S_EMIT;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        idx_in   = '0;
                        state_in = sle_pkg::S_REM_SCAN;
                     end
                  end
                  sle_pkg::OP_LIST_ASC, sle_pkg::OP_CLEAR: begin
                     if (is_empty) begin
                        status_in = sle_pkg::ST_EMPTY;
                        state_in  = sle_pkg::S_EMIT;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        idx_in   = '0;
                        state_in = sle_pkg::S_WALK;
                     end
                  end
                  sle_pkg::OP_LIST_DESC: begin
                     if (is_empty) begin
                        status_in = sle_pkg::ST_EMPTY;
                        state_in  = sle_pkg::S_EMIT;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = last_idx;
                        idx_in   = last_idx;
                        state_in = sle_pkg::S_WALK;
                     end
                  end
                  default: begin
                     // unused codes are dropped
                     state_in = sle_pkg::S_IDLE;
                  end
               endcase
            end
         end

         sle_pkg::S_INS: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff + sle_pkg::IDX_W'(1);
            if (cmp.lt) begin
               wr_data   = val_ff;
               cnt_in    = cnt_ff + sle_pkg::CNT_W'(1);
               status_in = sle_pkg::ST_OK;
               state_in  = sle_pkg::S_EMIT;
            end else begin
               wr_data = rdata_ff;
               if (idx_ff == '0) begin
                  state_in = sle_pkg::S_INS_HEAD;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - sle_pkg::IDX_W'(1);
                  idx_in  = idx_ff - sle_pkg::IDX_W'(1);
               end
            end
         end

         sle_pkg::S_INS_HEAD: begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = val_ff;
            cnt_in    = cnt_ff + sle_pkg::CNT_W'(1);
            status_in = sle_pkg::ST_OK;
            state_in  = sle_pkg::S_EMIT;
         end

         sle_pkg::S_REM_SCAN: begin
            if (cmp.eq) begin
               if (idx_ff == last_idx) begin
                  cnt_in    = cnt_ff - sle_pkg::CNT_W'(1);
                  status_in = sle_pkg::ST_OK;
                  state_in  = sle_pkg::S_EMIT;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = idx_ff + sle_pkg::IDX_W'(1);
                  idx_in   = idx_ff + sle_pkg::IDX_W'(1);
                  state_in = sle_pkg::S_REM_SHIFT;
               end
            end else if (idx_ff == last_idx) begin
               status_in = sle_pkg::ST_NOTFOUND;
               state_in  = sle_pkg::S_EMIT;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + sle_pkg::IDX_W'(1);
               idx_in  = idx_ff + sle_pkg::IDX_W'(1);
            end
         end

         sle_pkg::S_REM_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff - sle_pkg::IDX_W'(1);
            wr_data = rdata_ff;
            if (idx_ff == last_idx) begin
               cnt_in    = cnt_ff - sle_pkg::CNT_W'(1);
               status_in = sle_pkg::ST_OK;
               state_in  = sle_pkg::S_EMIT;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + sle_pkg::IDX_W'(1);
               idx_in  = idx_ff + sle_pkg::IDX_W'(1);
            end
         end

         sle_pkg::S_WALK: begin
            if (space) begin
               res.valid  = 1'b1;
               res.status = sle_pkg::ST_OK;
               res.value  = rdata_ff;
               res.last   = walk_end;
               if (walk_end) begin
                  if (op_ff == sle_pkg::OP_CLEAR) begin
                     cnt_in = '0;
                  end
                  state_in = sle_pkg::S_IDLE;
               end else begin
                  rd_en = 1'b1;
                  if (op_ff == sle_pkg::OP_LIST_DESC) begin
                     rd_addr = idx_ff - sle_pkg::IDX_W'(1);
                     idx_in  = idx_ff - sle_pkg::IDX_W'(1);
                  end else begin
                     rd_addr = idx_ff + sle_pkg::IDX_W'(1);
                     idx_in  = idx_ff + sle_pkg::IDX_W'(1);
                  end
               end
            end
         end

         sle_pkg::S_EMIT: begin
            if (space) begin
               res.valid  = 1'b1;
               res.status = status_ff;
               res.value  = '0;
               res.last   = 1'b1;
               state_in   = sle_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = sle_pkg::S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> hw/rtl/sorted_list_engine.sv
// sorted list engine: one item at a time, ready only while idle
// insert: entries not below the value shift up from the tail; the value goes into the gap
// remove: scan from the head to the first match, then shift the entries behind it down
// list and clear: one transfer per stored value; clear empties the list after the last one
// reset: synchronous, active high; empties the list and drops any pending result
`default_nettype none
module sorted_list_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [31:0]                   req_tdata,   // [31:0] value
   input  wire logic [sle_pkg::OP_W-1:0]      req_tuser,   // [2:0] operation
   // result channel
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [31:0]                        rsp_tdata,   // [31:0] value_res
   output logic [sle_pkg::ST_W-1:0]           rsp_tuser,   // [1:0] status
   output logic                               rsp_tlast
);

   sle_pkg::result_type             core_res;
   logic                            space;

   // output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sle_pkg::VAL_W-1:0]       rsp_data_ff, rsp_data_in;
   logic [sle_pkg::ST_W-1:0]        rsp_status_ff, rsp_status_in;
   logic                            rsp_last_ff, rsp_last_in;

   // the sequencer may hand over a result when the register is empty or draining
   assign space = !rsp_valid_ff || rsp_tready;

   sle_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser),
      .req_value (req_tdata),
      .space     (space),
      .res       (core_res)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (core_res.valid) begin
         // load a fresh result (space is guaranteed by the sequencer)
         rsp_valid_in  = 1'b1;
         rsp_data_in   = core_res.value;
         rsp_status_in = core_res.status;
         rsp_last_in   = core_res.last;
      end else if (rsp_tready) begin
         // transfer taken, nothing new behind it
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

>>> hw/rtl/sle_checker.sv
`default_nettype none
`include "sorted_list_engine_assert.svh"
module sle_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   input  wire logic                          req_tready,
   input  wire logic [sle_pkg::OP_W-1:0]      req_tuser,
   input  wire logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire logic [31:0]                   rsp_tdata,
   input  wire logic [sle_pkg::ST_W-1:0]      rsp_tuser,
   input  wire logic                          rsp_tlast
);

   // a stalled result holds
   `SLE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // one item at a time: busy right after a transfer of a defined operation
   `SLE_ASSERT_NXT(a_busy_after_req, clock, reset, req_tvalid && req_tready && (req_tuser <= sle_pkg::OP_CLEAR), !req_tready)

   // error results are single, zero-valued and last
   `SLE_ASSERT_IMP(a_status_only, clock, reset, rsp_tvalid && (rsp_tuser != sle_pkg::ST_OK), rsp_tlast && (rsp_tdata == '0))

   // nothing pending right after reset
   `SLE_ASSERT_IMP(a_reset_clear, clock, 1'b0, $past(reset), !rsp_tvalid)

endmodule

bind sorted_list_engine sle_checker u_sle_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
